/* src/go_back_n_sender_window_defines.svh */
// Assertion macros for the Go-Back-N sender window block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GBN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GBN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gbn_pkg.sv */
// Shared types and constants for the Go-Back-N sender window block.
// No dependencies; used by every module of the block.
package gbn_pkg;

  localparam int unsigned SEQ_W             = 4;  // sequence numbers modulo 16
  localparam int unsigned DUP_ACK_THRESHOLD = 3;
  localparam int unsigned DUP_W             = $clog2(DUP_ACK_THRESHOLD);
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam logic [SEQ_W-1:0] WINDOW_RESET = SEQ_W'(4);

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_RESEND  = 3'd2,
    ACT_REFUSED = 3'd3,
    ACT_ACKED   = 3'd4
  } action_e;

  // One queued job: expands into count result items with consecutive seq.
  typedef struct packed {
    action_e          action;
    logic [SEQ_W-1:0] seq;
    logic             tstart;
    logic             tstop;
    logic [SEQ_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/gbn_queue.sv */
// Small job queue between the front (classifier) and back (emitter).
// Depends on gbn_pkg.
module gbn_queue #(
  parameter int unsigned Depth = gbn_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gbn_pkg::push_t  push_i,
  input  logic            pop_i,
  output gbn_pkg::q_stat_t stat_o,
  output gbn_pkg::job_t   head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gbn_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push = push_i.valid && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

/* src/gbn_front.sv */
// Front end: accepts events, holds window state, turns each event into a job.
// Depends on gbn_pkg.
module gbn_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gbn_pkg::SEQ_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                cmd_i,
  input  logic [gbn_pkg::SEQ_W-1:0] ack_seq_i,
  input  logic                      ack_valid_i,
  input  gbn_pkg::q_stat_t          q_stat_i,
  output gbn_pkg::push_t            push_o
);

  localparam int unsigned SW = gbn_pkg::SEQ_W;
  localparam int unsigned DW = gbn_pkg::DUP_W;

  logic [SW-1:0] win_q;
  logic [SW-1:0] base_q, base_d, next_q, next_d;
  logic [DW-1:0] dup_q, dup_d;
  logic [DW:0]   dup_sum;
  logic [SW-1:0] outst, ack_off;
  logic          accept;
  gbn_pkg::cmd_e cmd;
  gbn_pkg::job_t job, resend_job;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat_i.full;
  assign accept      = in_valid_i && !q_stat_i.full;
  assign cmd         = gbn_pkg::cmd_e'(cmd_i);
  assign outst       = next_q - base_q;
  assign ack_off     = ack_seq_i - base_q;
  assign dup_sum     = {1'b0, dup_q} + (DW+1)'(1);

  // Retransmission of everything outstanding; a lone no-action item if empty.
  always_comb begin
    resend_job = '{action: gbn_pkg::ACT_NONE, seq: '0, tstart: 1'b0,
                   tstop: 1'b0, count: SW'(1)};
    if (outst != '0) begin
      resend_job = '{action: gbn_pkg::ACT_RESEND, seq: base_q, tstart: 1'b1,
                     tstop: 1'b0, count: outst};
    end
  end

  always_comb begin
    base_d = base_q;
    next_d = next_q;
    dup_d  = dup_q;
    job    = '{action: gbn_pkg::ACT_NONE, seq: '0, tstart: 1'b0,
               tstop: 1'b0, count: SW'(1)};
    unique case (cmd)
      gbn_pkg::CMD_SEND: begin
        if (outst < win_q) begin
          job.action = gbn_pkg::ACT_SEND;
          job.seq    = next_q;
          job.tstart = (outst == '0);
          next_d     = next_q + SW'(1);
        end else begin
          job.action = gbn_pkg::ACT_REFUSED;
        end
      end
      gbn_pkg::CMD_ACK: begin
        if (ack_valid_i) begin
          // duplicate of base - 1 is checked before the window test
          if (ack_seq_i == base_q - SW'(1)) begin
            if (dup_sum >= (DW+1)'(gbn_pkg::DUP_ACK_THRESHOLD)) begin
              dup_d = '0;
              job   = resend_job;
            end else begin
              dup_d = dup_sum[DW-1:0];
            end
          end else if (ack_off < outst) begin
            base_d     = ack_seq_i + SW'(1);
            dup_d      = '0;
            job.action = gbn_pkg::ACT_ACKED;
            job.tstop  = (ack_seq_i + SW'(1) == next_q);
          end
        end
      end
      gbn_pkg::CMD_TIMEOUT: begin
        job = resend_job;
      end
      gbn_pkg::CMD_UNUSED: begin
        job.action = gbn_pkg::ACT_NONE;
      end
      default: begin
        job.action = gbn_pkg::ACT_NONE;
      end
    endcase
  end

  assign push_o.valid = accept;
  assign push_o.job   = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= gbn_pkg::WINDOW_RESET;
      base_q <= '0;
      next_q <= '0;
      dup_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_q <= cfg_data_i;
      end
      if (accept) begin
        base_q <= base_d;
        next_q <= next_d;
        dup_q  <= dup_d;
      end
    end
  end

endmodule

/* src/gbn_back.sv */
// Back end: walks the head job item by item into the output register.
// Depends on gbn_pkg.
module gbn_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gbn_pkg::q_stat_t          q_stat_i,
  input  gbn_pkg::job_t             head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                action_o,
  output logic [gbn_pkg::SEQ_W-1:0] seq_out_o,
  output logic                      timer_start_o,
  output logic                      timer_stop_o,
  output logic                      last_o
);

  localparam int unsigned SW = gbn_pkg::SEQ_W;

  logic [SW-1:0]   idx_q, idx_d;
  logic            valid_q, valid_d;
  gbn_pkg::action_e action_q;
  logic [SW-1:0]   seq_q;
  logic            tstart_q, tstop_q, last_q;
  logic            load, is_last;

  assign load    = !q_stat_i.empty && (!valid_q || !out_stall_i);
  assign is_last = (idx_q == head_i.count - SW'(1));
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? '0 : idx_q + SW'(1);
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      action_q <= head_i.action;
      seq_q    <= head_i.seq + idx_q;
      tstart_q <= head_i.tstart && (idx_q == '0);
      tstop_q  <= head_i.tstop;
      last_q   <= is_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign action_o      = action_q;
  assign seq_out_o     = seq_q;
  assign timer_start_o = tstart_q;
  assign timer_stop_o  = tstop_q;
  assign last_o        = last_q;

endmodule

/* src/go_back_n_sender_window.sv */
// Go-Back-N sender window control, top level.
// Depends on gbn_pkg, gbn_front, gbn_queue, gbn_back and the defines header.
//
// Usage:
//   Events enter on the in channel (cmd_i, ack_seq_i, ack_valid_i) with
//   in_valid_i / in_stall_o. Results leave on the out channel (action_o,
//   seq_out_o, timer_start_o, timer_stop_o, last_o) with out_valid_o /
//   out_stall_i; last_o marks the final item of each event.
//   window_size is written through cfg_valid_i / cfg_ready_o / cfg_data_i
//   by the user only while the block is idle; the block does not enforce it.
// Timing:
//   The front classifies an event and updates the window state at the edge
//   that accepts it and queues one job; the back registers the first result
//   once the job reaches the queue head and the output is not stalled. It
//   emits one item per cycle while out_stall_i is low; a retransmission of n
//   outstanding packets yields n items (up to 15). The job queue (QueueDepth
//   entries) lets the front keep accepting while the back is busy; in_stall_o rises when it is full.
// Reset: window base, next sequence number and duplicate count clear,
//   window_size returns to 4, queue and output register empty.
// Receiver stall: the current item holds on the outputs; the queue fills
//   and then stalls the input side.
`include "go_back_n_sender_window_defines.svh"

module go_back_n_sender_window #(
  parameter int unsigned QueueDepth = gbn_pkg::QUEUE_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gbn_pkg::SEQ_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                cmd_i,
  input  logic [gbn_pkg::SEQ_W-1:0] ack_seq_i,
  input  logic                      ack_valid_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                action_o,
  output logic [gbn_pkg::SEQ_W-1:0] seq_out_o,
  output logic                      timer_start_o,
  output logic                      timer_stop_o,
  output logic                      last_o
);

  gbn_pkg::push_t   push;
  gbn_pkg::q_stat_t q_stat;
  gbn_pkg::job_t    head;
  logic             pop;

  gbn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .ack_seq_i   (ack_seq_i),
    .ack_valid_i (ack_valid_i),
    .q_stat_i    (q_stat),
    .push_o      (push)
  );

  gbn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (q_stat),
    .head_o (head)
  );

  gbn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .seq_out_o     (seq_out_o),
    .timer_start_o (timer_start_o),
    .timer_stop_o  (timer_stop_o),
    .last_o        (last_o)
  );

  // every queued job yields at least one item
  `GBN_ASSERT_IMP(a_job_nonempty, push.valid, push.job.count != '0,
                  "queued job with zero items")

  // a retransmission burst continues without a gap, seq counting up
  `GBN_ASSERT_NXT(a_resend_burst,
                  out_valid_o && !out_stall_i && !last_o && action_o == gbn_pkg::ACT_RESEND,
                  out_valid_o && action_o == gbn_pkg::ACT_RESEND &&
                  seq_out_o == $past(seq_out_o) + gbn_pkg::SEQ_W'(1),
                  "retransmission burst broken")

  // the timer is never started and stopped by the same item
  `GBN_ASSERT_IMP(a_timer_excl, out_valid_o, !(timer_start_o && timer_stop_o),
                  "timer start and stop together")

endmodule
